// ----- rtl/core/epd_pkg.sv -----
// Shared types and constants for the escaped packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package epd_pkg;

    // Register indexes on the configuration port
    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_ESCAPE = 1'b1;

    localparam logic [7:0] HEADER_RESET = 8'd2;
    localparam logic [7:0] ESCAPE_RESET = 8'd16;

    // Packet layout, positions counted from the header at 0
    localparam logic [16:0] POS_SEQ_FIRST     = 17'd1;
    localparam logic [16:0] POS_SEQ_LAST      = 17'd4;
    localparam logic [16:0] POS_RECEIPT       = 17'd5;
    localparam logic [16:0] POS_LEN_LO        = 17'd9;
    localparam logic [16:0] POS_LEN_HI        = 17'd10;
    localparam logic [16:0] POS_FIRST_PAYLOAD = 17'd11;

    // Operation kinds passed from the front to the back
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_ABORT = 2'd2;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] escape;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;   // decoded byte, or header value for a start
        logic [16:0] pos;
        logic        last;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage

`default_nettype wire

// ----- rtl/core/epd_in_if.sv -----
// Raw byte channel into the deframer.
`timescale 1ns / 1ps
`default_nettype none

interface epd_in_if ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       line_timeout;

    modport source (output valid, output rx_byte, output line_timeout, input ready);
    modport sink   (input valid, input rx_byte, input line_timeout, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/epd_out_if.sv -----
// Decoded byte channel out of the deframer.
`timescale 1ns / 1ps
`default_nettype none

interface epd_out_if ();
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [16:0] byte_index;
    logic        last;
    logic        aborted;
    logic        checksum_ok;
    logic [31:0] sequence_number;
    logic [7:0]  receipt_type;
    logic [15:0] payload_length;

    modport source (
        output valid, output data_byte, output byte_index, output last,
        output aborted, output checksum_ok, output sequence_number,
        output receipt_type, output payload_length, input ready
    );
    modport sink (
        input valid, input data_byte, input byte_index, input last,
        input aborted, input checksum_ok, input sequence_number,
        input receipt_type, input payload_length, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/epd_front.sv -----
// Front end: header hunt, unstuffing and packet framing.
`timescale 1ns / 1ps
`default_nettype none

module epd_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  epd_pkg::t_cfg  i_cfg,
    input  wire            i_q_full,
    output epd_pkg::t_push o_push,
    epd_in_if.sink         i_rx
);
    import epd_pkg::*;

    logic        r_in_pkt, n_in_pkt;
    logic        r_esc, n_esc;
    logic [16:0] r_cnt, n_cnt;
    logic [15:0] r_len, n_len;

    logic       accept;
    logic [7:0] decoded;
    logic       is_last;

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && !i_q_full;
    assign decoded    = i_rx.rx_byte + {7'd0, r_esc};
    assign is_last    = (r_cnt == (POS_FIRST_PAYLOAD + {1'b0, r_len}));

    always_comb begin
        n_in_pkt           = r_in_pkt;
        n_esc              = r_esc;
        n_cnt              = r_cnt;
        n_len              = r_len;
        o_push.push        = 1'b0;
        o_push.entry.kind  = OP_DATA;
        o_push.entry.data  = decoded;
        o_push.entry.pos   = r_cnt;
        o_push.entry.last  = is_last;
        if (accept) begin
            if (!r_in_pkt) begin
                if (!i_rx.line_timeout && i_rx.rx_byte == i_cfg.header) begin
                    o_push.push       = 1'b1;
                    o_push.entry.kind = OP_START;
                    o_push.entry.data = i_cfg.header;
                    o_push.entry.last = 1'b0;
                    n_in_pkt          = 1'b1;
                    n_esc             = 1'b0;
                    n_cnt             = POS_SEQ_FIRST;
                    n_len             = 16'd0;
                end
            end else if (i_rx.line_timeout) begin
                o_push.push       = 1'b1;
                o_push.entry.kind = OP_ABORT;
                o_push.entry.last = 1'b0;
                n_in_pkt          = 1'b0;
                n_esc             = 1'b0;
                n_cnt             = 17'd0;
            end else if (i_rx.rx_byte == i_cfg.escape) begin
                n_esc = 1'b1;
            end else begin
                o_push.push = 1'b1;
                n_esc       = 1'b0;
                if (r_cnt == POS_LEN_LO) begin
                    n_len[7:0] = decoded;
                end
                if (r_cnt == POS_LEN_HI) begin
                    n_len[15:8] = decoded;
                end
                if (is_last) begin
                    n_in_pkt = 1'b0;
                    n_cnt    = 17'd0;
                end else begin
                    n_cnt = r_cnt + 17'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pkt <= 1'b0;
            r_esc    <= 1'b0;
            r_cnt    <= 17'd0;
            r_len    <= 16'd0;
        end else begin
            r_in_pkt <= n_in_pkt;
            r_esc    <= n_esc;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
        end
    end

    // escape flag only lives inside a packet
    a_esc_in_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> r_in_pkt)
        else $error("escape pending while hunting");

endmodule

`default_nettype wire

// ----- rtl/core/epd_queue.sv -----
// Short register queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module epd_queue #(
    parameter int DEPTH = 4
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  epd_pkg::t_push i_push,
    input  wire            i_pop,
    output epd_pkg::t_head o_head,
    output logic           o_full
);
    import epd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_pop;

    assign o_full       = (r_count == CNT_FULL);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd];
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.push) begin
            n_wr = (r_wr == PTR_MAX) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_MAX) ? '0 : r_rd + PTR_W'(1);
        end
        case ({i_push.push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.push && o_full))
        else $error("push into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- rtl/core/epd_back.sv -----
// Back end: field capture, checksum and output register.
`timescale 1ns / 1ps
`default_nettype none

module epd_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  epd_pkg::t_head i_head,
    output logic           o_pop,
    epd_out_if.source      o_res
);
    import epd_pkg::*;

    logic [7:0]  r_xor, n_xor;
    logic [31:0] r_seq, n_seq;
    logic [7:0]  r_rcpt, n_rcpt;
    logic [15:0] r_len, n_len;

    logic        r_valid;
    logic [7:0]  r_data;
    logic [16:0] r_pos;
    logic        r_last;
    logic        r_abort;
    logic        r_ck;
    logic [31:0] r_oseq;
    logic [7:0]  r_orcpt;
    logic [15:0] r_olen;

    logic   can_load;
    logic   load;
    t_entry e;

    assign e        = i_head.entry;
    assign can_load = !r_valid || o_res.ready;
    assign o_pop    = i_head.valid && ((e.kind == OP_START) || can_load);
    assign load     = o_pop && (e.kind != OP_START);

    always_comb begin
        n_xor  = r_xor;
        n_seq  = r_seq;
        n_rcpt = r_rcpt;
        n_len  = r_len;
        if (o_pop) begin
            if (e.kind == OP_START) begin
                n_xor  = e.data;
                n_seq  = 32'd0;
                n_rcpt = 8'd0;
                n_len  = 16'd0;
            end else if (e.kind == OP_DATA) begin
                if (!e.last) begin
                    n_xor = r_xor ^ e.data;
                end
                unique case (e.pos)
                    POS_SEQ_FIRST:   n_seq[7:0]   = e.data;
                    17'd2:           n_seq[15:8]  = e.data;
                    17'd3:           n_seq[23:16] = e.data;
                    POS_SEQ_LAST:    n_seq[31:24] = e.data;
                    POS_RECEIPT:     n_rcpt       = e.data;
                    POS_LEN_LO:      n_len[7:0]   = e.data;
                    POS_LEN_HI:      n_len[15:8]  = e.data;
                    default:         n_len        = r_len;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor  <= 8'd0;
            r_seq  <= 32'd0;
            r_rcpt <= 8'd0;
            r_len  <= 16'd0;
        end else begin
            r_xor  <= n_xor;
            r_seq  <= n_seq;
            r_rcpt <= n_rcpt;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload: abort beats carry zeros, meta fields only ride with last
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (e.kind == OP_ABORT) begin
                r_data  <= 8'd0;
                r_pos   <= 17'd0;
                r_last  <= 1'b0;
                r_abort <= 1'b1;
                r_ck    <= 1'b0;
                r_oseq  <= 32'd0;
                r_orcpt <= 8'd0;
                r_olen  <= 16'd0;
            end else begin
                r_data  <= e.data;
                r_pos   <= e.pos;
                r_last  <= e.last;
                r_abort <= 1'b0;
                r_ck    <= e.last && (e.data == r_xor);
                r_oseq  <= e.last ? r_seq  : 32'd0;
                r_orcpt <= e.last ? r_rcpt : 8'd0;
                r_olen  <= e.last ? r_len  : 16'd0;
            end
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.data_byte       = r_data;
    assign o_res.byte_index      = r_pos;
    assign o_res.last            = r_last;
    assign o_res.aborted         = r_abort;
    assign o_res.checksum_ok     = r_ck;
    assign o_res.sequence_number = r_oseq;
    assign o_res.receipt_type    = r_orcpt;
    assign o_res.payload_length  = r_olen;

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_pos == POS_FIRST_PAYLOAD + {1'b0, r_olen}))
        else $error("closing byte at wrong position");

    a_abort_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_abort) |-> (!r_last && r_pos == 17'd0))
        else $error("abort beat carries data fields");

endmodule

`default_nettype wire

// ----- rtl/core/escaped_packet_deframer.sv -----
// Escaped packet deframer: top level.
//
// Usage:
//   i_rx_ch carries one raw serial byte per beat (rx_byte) plus a line
//   timeout flag. o_res_ch carries one decoded byte per beat with its
//   position in the packet; the header (position 0) and escape bytes
//   make no beat. The closing checksum beat has last set and brings the
//   checksum check, sequence number, receipt type and payload length.
//   A timeout inside a packet makes one beat with aborted set.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 = header byte, 1 = escape byte); write only while idle.
// Timing:
//   An input beat passes a queue slot, then the output register, on its
//   way to the output. Throughput is 1 byte per cycle while the receiver
//   does not stall, set by the one-byte front decoder and the one-entry
//   back stage. When the receiver stalls, the output register holds and
//   the queue fills; i_rx_ch.ready drops only once QUEUE_DEPTH ops wait.
// Reset:
//   Synchronous, active low: block hunts for a header, queue empty,
//   registers back to header 2 / escape 16.
`timescale 1ns / 1ps
`default_nettype none

module escaped_packet_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire [7:0]  i_cfg_data,
    epd_in_if.sink     i_rx_ch,
    epd_out_if.source  o_res_ch
);
    import epd_pkg::*;

    logic [7:0] r_header;
    logic [7:0] r_escape;
    t_cfg       cfg;

    t_push push;
    t_head head;
    logic  q_full;
    logic  pop;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_escape <= ESCAPE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_HEADER) begin
                r_header <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_ESCAPE) begin
                r_escape <= i_cfg_data;
            end
        end
    end

    assign cfg.header = r_header;
    assign cfg.escape = r_escape;

    // front: hunt, unstuff, count positions, detect the closing byte
    epd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .i_rx     (i_rx_ch)
    );

    // op queue decouples line intake from output stalls
    epd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    // back: captures, running XOR, output register
    epd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res_ch)
    );

endmodule

`default_nettype wire

// ----- bench/tb_escaped_packet_deframer.sv -----
// Testbench for escaped_packet_deframer: stuffed packet traffic checked against a local model.
`timescale 1ns / 1ps

module tb_escaped_packet_deframer;
    import epd_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 12;
    localparam int SETTLE_WAIT = 8;     // drain time past the queue slot and output register
    localparam int HOLD_CYCLES = 100;   // long receiver hold-off for the back-pressure check
    localparam int QUIET_LIMIT = 1000;  // cycles without any beat before the run is abandoned

    // Packet shapes the generator can build
    localparam int PKT_GOOD    = 0;
    localparam int PKT_BAD_SUM = 1;
    localparam int PKT_CUT     = 2;

    // One raw line byte plus the idle cycles the sender waits before offering it
    typedef struct {
        logic [7:0]  raw;
        logic        tmo;
        int unsigned gap;
    } t_line_item;

    // One decoded output beat as the deframer should present it
    typedef struct packed {
        logic [7:0]  data;
        logic [16:0] idx;
        logic        last;
        logic        aborted;
        logic        csum_ok;
        logic [31:0] seq;
        logic [7:0]  rtype;
        logic [15:0] plen;
    } t_res_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    epd_in_if  rx_if ();
    epd_out_if res_if ();

    escaped_packet_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_ch    (rx_if),
        .o_res_ch   (res_if)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Deframer model: register copies and packet state
    // ------------------------------------------------------------------
    logic [7:0]  hdr_reg  = HEADER_RESET;
    logic [7:0]  esc_reg  = ESCAPE_RESET;
    logic        in_pkt   = 1'b0;
    logic        esc_seen = 1'b0;
    logic [16:0] next_pos = '0;
    logic [7:0]  xor_acc  = '0;
    logic [31:0] seq_acc  = '0;
    logic [7:0]  rcpt_acc = '0;
    logic [15:0] len_acc  = '0;

    t_res_beat   due_beats[$];     // decoded beats still owed by the DUT
    t_line_item  line_bytes[$];    // raw bytes waiting for the sender

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned src_max_gap  = 0;
    int unsigned snk_max_gap  = 0;
    int unsigned hold_asked   = 0;
    int unsigned hold_served  = 0;

    // Runs one accepted raw byte through the deframer rules and queues any beat it causes.
    task automatic deframe_byte(input logic [7:0] raw, input logic tmo);
        t_res_beat   beat;
        logic [7:0]  dec;
        logic [16:0] p;
        beat = '0;
        if (!in_pkt) begin
            // hunting: a timeout is ignored, only the header byte opens a packet
            if (!tmo && raw == hdr_reg) begin
                in_pkt   = 1'b1;
                esc_seen = 1'b0;
                next_pos = POS_SEQ_FIRST;
                xor_acc  = hdr_reg;      // checksum covers the header too
                seq_acc  = '0;
                rcpt_acc = '0;
                len_acc  = '0;
            end
        end else if (tmo) begin
            in_pkt       = 1'b0;
            esc_seen     = 1'b0;
            next_pos     = '0;
            beat.aborted = 1'b1;
            due_beats.push_back(beat);
        end else if (raw == esc_reg) begin
            // escape is dropped; a second escape just keeps the flag set
            esc_seen = 1'b1;
        end else begin
            dec      = raw + {7'd0, esc_seen};   // escaped 255 wraps to 0
            esc_seen = 1'b0;
            p        = next_pos;
            if (p >= POS_SEQ_FIRST && p <= POS_SEQ_LAST)
                seq_acc = seq_acc | (32'(dec) << (8 * (p - POS_SEQ_FIRST)));
            else if (p == POS_RECEIPT)
                rcpt_acc = dec;
            else if (p == POS_LEN_LO)
                len_acc[7:0] = dec;
            else if (p == POS_LEN_HI)
                len_acc[15:8] = dec;
            beat.data = dec;
            beat.idx  = p;
            if (p >= POS_FIRST_PAYLOAD && p == POS_FIRST_PAYLOAD + {1'b0, len_acc}) begin
                beat.last    = 1'b1;
                beat.csum_ok = (dec == xor_acc);
                beat.seq     = seq_acc;
                beat.rtype   = rcpt_acc;
                beat.plen    = len_acc;
                in_pkt       = 1'b0;
                next_pos     = '0;
            end else begin
                xor_acc  = xor_acc ^ dec;
                next_pos = p + 17'd1;
            end
            due_beats.push_back(beat);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: samples acceptance at the rising edge, drives at the falling edge
    // ------------------------------------------------------------------
    logic        rx_fire = 1'b0;
    t_line_item  cur_item;
    bit          have_item = 1'b0;
    int unsigned gap_left  = 0;

    always @(posedge i_clk) begin
        rx_fire <= i_rst_n && rx_if.valid && rx_if.ready;
        if (i_rst_n && rx_if.valid && rx_if.ready) begin
            deframe_byte(rx_if.rx_byte, rx_if.line_timeout);
            bytes_taken <= bytes_taken + 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
            have_item = 1'b0;
        end else begin
            if (rx_fire)
                have_item = 1'b0;
            if (!have_item && line_bytes.size() != 0) begin
                cur_item  = line_bytes.pop_front();
                have_item = 1'b1;
                gap_left  = cur_item.gap;
            end
            // valid stays up across back-to-back beats: one assignment per edge
            if (have_item && gap_left == 0) begin
                rx_if.valid        <= 1'b1;
                rx_if.rx_byte      <= cur_item.raw;
                rx_if.line_timeout <= cur_item.tmo;
            end else begin
                if (have_item)
                    gap_left--;
                rx_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls per beat, plus an occasional long hold-off
    // ------------------------------------------------------------------
    logic        res_fire = 1'b0;
    int unsigned snk_wait  = 0;
    int unsigned hold_left = 0;

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res_beat want;
        res_fire <= i_rst_n && res_if.valid && res_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_beats.size() == 0) begin
                $error("beat with nothing due: data %0h index %0d", res_if.data_byte,
                       res_if.byte_index);
                mismatches++;
            end else begin
                want = due_beats.pop_front();
                check_field("data_byte",       want.data,  res_if.data_byte);
                check_field("byte_index",      want.idx,   res_if.byte_index);
                check_field("last",            want.last,  res_if.last);
                check_field("aborted",         want.aborted, res_if.aborted);
                check_field("checksum_ok",     want.csum_ok, res_if.checksum_ok);
                check_field("sequence_number", want.seq,   res_if.sequence_number);
                check_field("receipt_type",    want.rtype, res_if.receipt_type);
                check_field("payload_length",  want.plen,  res_if.payload_length);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            snk_wait  = 0;
            hold_left = 0;
        end else begin
            if (hold_served != hold_asked) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (res_fire)
                snk_wait = $urandom_range(0, snk_max_gap);
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (snk_wait > 0) begin
                snk_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: any stretch with no beat on either side longer than the limit is a hang
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_line(input logic [7:0] raw, input logic tmo);
        t_line_item item;
        item.raw = raw;
        item.tmo = tmo;
        item.gap = $urandom_range(0, src_max_gap);
        line_bytes.push_back(item);
        bytes_queued++;
    endtask

    // Payload content leaning toward the values that matter to the framing
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return hdr_reg;
            1:       return esc_reg;
            2:       return 8'h00;
            3:       return 8'hFF;
            4:       return esc_reg + 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Stuffs one decoded byte; an escape value must be escaped, others sometimes are
    task automatic stuff_byte(input logic [7:0] d, ref logic [7:0] raw_seq[$]);
        if (d == esc_reg) begin
            raw_seq.push_back(esc_reg);
            raw_seq.push_back(d - 8'd1);
        end else if (d - 8'd1 != esc_reg && $urandom_range(0, 7) == 0) begin
            raw_seq.push_back(esc_reg);
            if ($urandom_range(0, 3) == 0)
                raw_seq.push_back(esc_reg);   // repeated escape
            raw_seq.push_back(d - 8'd1);
        end else begin
            raw_seq.push_back(d);
        end
    endtask

    task automatic queue_packet(input int unsigned plen, input int kind);
        logic [7:0]  body[$];
        logic [7:0]  raw_seq[$];
        logic [7:0]  sum;
        int unsigned keep;
        for (int i = 0; i < 8; i++)
            body.push_back((i < 4 && $urandom_range(0, 1)) ? pick_byte()
                                                           : 8'($urandom_range(0, 255)));
        body.push_back(8'(plen));
        body.push_back(8'(plen >> 8));
        for (int unsigned i = 0; i < plen; i++)
            body.push_back(pick_byte());
        sum = hdr_reg;
        foreach (body[i])
            sum = sum ^ body[i];
        if (kind == PKT_BAD_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        body.push_back(sum);
        foreach (body[i])
            stuff_byte(body[i], raw_seq);
        push_line(hdr_reg, 1'b0);
        if (kind == PKT_CUT) begin
            // line goes quiet part way through: timeout byte content is junk
            keep = $urandom_range(0, raw_seq.size() - 1);
            for (int unsigned i = 0; i < keep; i++)
                push_line(raw_seq[i], 1'b0);
            push_line(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            foreach (raw_seq[i])
                push_line(raw_seq[i], 1'b0);
        end
    endtask

    // Line noise while hunting, closed by a timeout in case it held a header
    task automatic queue_noise();
        int unsigned n;
        n = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n; i++)
            push_line(8'($urandom_range(0, 255)), 1'b0);
        push_line(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic random_traffic(input int unsigned n_items);
        int unsigned start;
        int unsigned plen;
        start = bytes_queued;
        while (bytes_queued - start < n_items) begin
            plen = ($urandom_range(0, 14) == 0) ? $urandom_range(13, 60)
                                                : $urandom_range(0, 12);
            case ($urandom_range(0, 9))
                0:       queue_noise();
                1:       queue_packet(plen, PKT_CUT);
                2:       queue_packet(plen, PKT_BAD_SUM);
                default: queue_packet(plen, PKT_GOOD);
            endcase
        end
    endtask

    // Wait until every byte is in and every beat is out, then let the pipe drain
    task automatic settle();
        while (!(bytes_taken == bytes_queued && due_beats.size() == 0))
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEADER)
            hdr_reg = val;
        else
            esc_reg = val;
    endtask

    task automatic run_phase(input logic [7:0] hdr, input logic [7:0] esc,
                             input int unsigned src_gap, input int unsigned snk_gap,
                             input int unsigned n_items);
        settle();
        write_reg(CFG_HEADER, hdr);
        write_reg(CFG_ESCAPE, esc);
        @(posedge i_clk);
        src_max_gap = src_gap;
        snk_max_gap = snk_gap;
        random_traffic(n_items);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_HEADER;
        i_cfg_data         = '0;
        rx_if.valid        = 1'b0;
        rx_if.rx_byte      = '0;
        rx_if.line_timeout = 1'b0;
        res_if.ready       = 1'b0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed packet on the reset register values (header 2, escape 16)
        @(posedge i_clk);
        src_max_gap = 19;
        snk_max_gap = 19;
        push_line(8'h00, 1'b1);                 // timeout while hunting
        push_line(8'hFF, 1'b0);                 // noise, not a header
        push_line(HEADER_RESET, 1'b0);
        push_line(ESCAPE_RESET, 1'b0);          // pos 1: escaped escape value
        push_line(ESCAPE_RESET - 8'd1, 1'b0);
        push_line(ESCAPE_RESET, 1'b0);          // pos 2: escaped 255 wraps to 0
        push_line(8'hFF, 1'b0);
        push_line(HEADER_RESET, 1'b0);          // pos 3: header value is plain data here
        push_line(ESCAPE_RESET, 1'b0);          // pos 4: escape twice, then 7f -> 80
        push_line(ESCAPE_RESET, 1'b0);
        push_line(8'h7F, 1'b0);
        push_line(8'hFF, 1'b0);                 // receipt type
        push_line(8'hAA, 1'b0);
        push_line(8'h55, 1'b0);
        push_line(8'h00, 1'b0);
        push_line(8'h00, 1'b0);                 // length 0
        push_line(8'h00, 1'b0);
        push_line(8'h90, 1'b0);                 // matching checksum
        push_line(HEADER_RESET, 1'b0);          // packet cut by timeout
        push_line(8'h33, 1'b0);
        push_line(8'hC3, 1'b1);

        // Random phases across register settings and idle profiles
        run_phase(8'h00, 8'hFF, 19, 19, 140);
        run_phase(8'hFF, 8'h00, 0, 19, 140);
        run_phase(8'h55, 8'h55, 19, 0, 140);
        run_phase(8'h7E, 8'h7D, 0, 0, 140);

        // Back-pressure: receiver holds off while the sender streams a packet
        settle();
        @(posedge i_clk);
        src_max_gap = 0;
        snk_max_gap = 0;
        hold_asked++;
        queue_packet(40, PKT_GOOD);

        run_phase(HEADER_RESET, ESCAPE_RESET, 19, 19, 140);

        settle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
